[design/dpw_pkg.sv]
// Shared types and constants of the DPW sawtooth oscillator.
package dpw_pkg;

	localparam int OUT_BITS_DEF = 24;
	localparam int CFG_IDX_W    = 2;
	localparam int ACC_W        = 128;
	localparam int PATH_W       = 41;

	localparam logic [PATH_W-1:0] PATH_CAP = 41'h100_0000_0000;
	localparam logic [16:0]       G_ONE    = 17'h1_0000;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PHASE_INC,
		CFG_DPW2_GAIN,
		CFG_DPW4_GAIN,
		CFG_MIX_WEIGHT
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SQ,
		ST_X4,
		ST_DIFF,
		ST_D1,
		ST_D2,
		ST_D3,
		ST_P2,
		ST_C2,
		ST_P4,
		ST_C4,
		ST_MIX,
		ST_ABS,
		ST_OUT
	} step_t;

	typedef struct packed {
		step_t      step;
		logic [2:0] cnt;
		logic       issue;
	} ctrl_t;

	typedef enum logic [1:0] {
		SH_0,
		SH_32,
		SH_64
	} mac_shift_t;

	typedef struct packed {
		logic        issue;
		logic        load;
		logic        sub;
		mac_shift_t  shift;
		logic [31:0] a;
		logic [31:0] b;
	} mac_op_t;

endpackage

[design/dpw_saw_oscillator.sv]
// Top level of the DPW2/DPW4 crossfaded sawtooth oscillator.
// Usage: each item on the input channel (in_valid/in_ready, field restart)
// asks for one sample; the sample leaves on the output channel
// (out_valid/out_ready, field sample, signed Q1.(OUT_BITS-1), saturated).
// restart = 1 clears phase and all differentiator history before the sample.
// Registers are written on the cfg channel (cfg_valid/cfg_ready, cfg_index,
// cfg_data); the user must write them only while no item is in flight, which
// the block does not enforce; cfg_ready is always high.
// The block takes no new item while one is in flight. Every product goes through the one
// 32x32 multiplier with a 128-bit accumulator: 1 partial product for the
// square, 4 each for x^4, both path gains and the mix, each group followed
// by a drain, and eight steps for differences and saturation.
// in_ready is high only while the sequencer is idle.
// If the receiver stalls, the finished sample waits in the output register and
// the sequencer holds in its last step until the register frees.
// Reset clears registers, phase and history to zero; no clearing pass is needed.
module dpw_saw_oscillator #(
	parameter int OUT_BITS = dpw_pkg::OUT_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           restart,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic signed [OUT_BITS-1:0]     sample,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [dpw_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [63:0]                    cfg_data
);
	import dpw_pkg::*;

	localparam int SHR = 85 - OUT_BITS;
	localparam logic [PATH_W-1:0] MAG_MAX = PATH_W'((64'd1 << (OUT_BITS - 1)) - 64'd1);
	localparam logic [PATH_W-1:0] MAG_MIN = PATH_W'(64'd1 << (OUT_BITS - 1));

	ctrl_t            ctrl;
	mac_op_t          mac_op;
	logic [ACC_W-1:0] acc;
	logic             in_fire;
	logic             out_free;

	logic [31:0]       inc_q;
	logic [63:0]       gain2_q;
	logic [63:0]       gain4_q;
	logic [16:0]       wt_q;
	logic [31:0]       phase_q;
	logic [63:0]       hist4_q [3];
	logic [63:0]       hist2_q;

	logic [31:0]       m_q;
	logic [60:0]       x2_q;
	logic [63:0]       dif_q;
	logic [63:0]       dq_q;
	logic [63:0]       mag2_q;
	logic [63:0]       mag4_q;
	logic              neg2_q;
	logic              neg4_q;
	logic [PATH_W-1:0] r2_q;
	logic [PATH_W-1:0] r4_q;
	logic [PATH_W-1:0] absmag_q;
	logic              vneg_q;
	logic              out_valid_q;
	logic [OUT_BITS-1:0] sample_q;

	logic [31:0]       m_now;
	logic [60:0]       x2_w;
	logic [63:0]       x4;
	logic [63:0]       poly;
	logic [63:0]       dq;
	logic [63:0]       dsub;
	logic [ACC_W-1:0]  q_shr;
	logic              over;
	logic [PATH_W-1:0] r_sat;
	logic [63:0]       v;
	logic [63:0]       v_abs;
	logic [16:0]       g;
	logic [16:0]       w2;
	logic [63:0]       op_a;
	logic [63:0]       op_b;
	logic [1:0]        k;
	logic [PATH_W-1:0] r_sel;
	logic [OUT_BITS-1:0] res;

	dpw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.out_free (out_free),
		.ctrl     (ctrl)
	);

	dpw_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (mac_op),
		.acc    (acc)
	);

	assign in_ready  = (ctrl.step == ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign sample    = sample_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inc_q   <= '0;
			gain2_q <= '0;
			gain4_q <= '0;
			wt_q    <= '0;
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				CFG_PHASE_INC:  inc_q   <= cfg_data[31:0];
				CFG_DPW2_GAIN:  gain2_q <= cfg_data;
				CFG_DPW4_GAIN:  gain4_q <= cfg_data;
				CFG_MIX_WEIGHT: wt_q    <= cfg_data[16:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		m_now = phase_q[31] ? {1'b0, phase_q[30:0]} : (32'h8000_0000 - phase_q);
		x2_w  = (ctrl.cnt == 3'd0) ? acc[62:2] : x2_q;
		x4    = acc[123:60];
		poly  = x4 - {2'b00, x2_q, 1'b0};
		dq    = {3'b000, x2_q} - hist2_q;
		case (ctrl.step)
			ST_D1:   dsub = dif_q - hist4_q[0];
			ST_D2:   dsub = dif_q - hist4_q[1];
			default: dsub = dif_q - hist4_q[2];
		endcase
		q_shr = acc >> SHR;
		over  = (|q_shr[ACC_W-1:PATH_W]) || (q_shr[PATH_W-1] && (|q_shr[PATH_W-2:0]));
		r_sat = over ? PATH_CAP : q_shr[PATH_W-1:0];
		v     = acc[63:0];
		v_abs = v[63] ? (64'd0 - v) : v;
		g     = wt_q[16] ? G_ONE : wt_q;
		w2    = G_ONE - g;
	end

	// operand select for the shared multiplier
	always_comb begin
		k      = ctrl.cnt[1:0];
		op_a   = '0;
		op_b   = '0;
		r_sel  = k[1] ? r2_q : r4_q;
		mac_op = '{issue: ctrl.issue, load: (k == 2'd0), sub: 1'b0, shift: SH_0,
			a: 32'd0, b: 32'd0};
		case (ctrl.step)
			ST_SQ: begin
				op_a = {32'd0, m_q};
				op_b = {32'd0, m_q};
			end
			ST_X4: begin
				op_a = {3'd0, x2_w};
				op_b = {3'd0, x2_w};
			end
			ST_P2: begin
				op_a = mag2_q;
				op_b = gain2_q;
			end
			ST_P4: begin
				op_a = mag4_q;
				op_b = gain4_q;
			end
			default: ;
		endcase
		if (ctrl.step == ST_MIX) begin
			mac_op.a     = {15'd0, (k[1] ? w2 : g)};
			mac_op.b     = k[0] ? {23'd0, r_sel[PATH_W-1:32]} : r_sel[31:0];
			mac_op.sub   = k[1] ? neg2_q : neg4_q;
			mac_op.shift = k[0] ? SH_32 : SH_0;
		end else begin
			// partial products: lo*lo, lo*hi, hi*lo, hi*hi
			mac_op.a = k[1] ? op_a[63:32] : op_a[31:0];
			mac_op.b = k[0] ? op_b[63:32] : op_b[31:0];
			case (k)
				2'd0:    mac_op.shift = SH_0;
				2'd3:    mac_op.shift = SH_64;
				default: mac_op.shift = SH_32;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= '0;
			hist4_q[0] <= '0;
			hist4_q[1] <= '0;
			hist4_q[2] <= '0;
			hist2_q    <= '0;
		end else begin
			if (in_fire && restart) begin
				phase_q    <= '0;
				hist4_q[0] <= '0;
				hist4_q[1] <= '0;
				hist4_q[2] <= '0;
				hist2_q    <= '0;
			end
			case (ctrl.step)
				ST_DIFF: begin
					phase_q <= phase_q + inc_q;
					hist2_q <= {3'b000, x2_q};
				end
				ST_D1:   hist4_q[0] <= dif_q;
				ST_D2:   hist4_q[1] <= dif_q;
				ST_D3:   hist4_q[2] <= dif_q;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			m_q <= restart ? 32'h8000_0000 : m_now;
		end
		case (ctrl.step)
			ST_X4: begin
				if (ctrl.cnt == 3'd0) begin
					x2_q <= x2_w;
				end
			end
			ST_DIFF: begin
				dif_q <= poly;
				dq_q  <= dq;
			end
			ST_D1: begin
				dif_q  <= dsub;
				neg2_q <= dq_q[63];
				mag2_q <= dq_q[63] ? (64'd0 - dq_q) : dq_q;
			end
			ST_D2, ST_D3: dif_q <= dsub;
			ST_C2: begin
				r2_q   <= r_sat;
				neg4_q <= dif_q[63];
				mag4_q <= dif_q[63] ? (64'd0 - dif_q) : dif_q;
			end
			ST_C4:  r4_q <= r_sat;
			ST_ABS: begin
				vneg_q   <= v[63];
				absmag_q <= v_abs[56:16];
			end
			default: ;
		endcase
	end

	// saturate the truncated mix to the output range
	always_comb begin
		if (!vneg_q) begin
			res = (absmag_q > MAG_MAX) ? MAG_MAX[OUT_BITS-1:0] : absmag_q[OUT_BITS-1:0];
		end else begin
			res = (absmag_q > MAG_MIN) ? MAG_MIN[OUT_BITS-1:0]
				: ('0 - absmag_q[OUT_BITS-1:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.step == ST_OUT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.step == ST_OUT && out_free) begin
			sample_q <= res;
		end
	end

	a_out_from_seq: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(ctrl.step == ST_OUT))
		else $error("output register loaded outside the output step");

	a_restart_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && restart) |=> (m_q == 32'h8000_0000 && phase_q == 32'd0))
		else $error("restart did not clear the phase");

endmodule

[design/dpw_mac.sv]
// Shared 32x32 multiplier with a 128-bit shift-and-accumulate register.
module dpw_mac (
	input  logic                       clk,
	input  logic                       arst_n,
	input  dpw_pkg::mac_op_t           op,
	output logic [dpw_pkg::ACC_W-1:0]  acc
);
	import dpw_pkg::*;

	logic [63:0]      prod_s1;
	logic             issue_s1;
	logic             load_s1;
	logic             sub_s1;
	mac_shift_t       shift_s1;
	logic [ACC_W-1:0] acc_q;
	logic [ACC_W-1:0] term;
	logic [ACC_W-1:0] base;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_s1 <= 1'b0;
		end else begin
			issue_s1 <= op.issue;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1  <= op.a * op.b;
		load_s1  <= op.load;
		sub_s1   <= op.sub;
		shift_s1 <= op.shift;
	end

	always_comb begin
		case (shift_s1)
			SH_0:    term = {64'd0, prod_s1};
			SH_32:   term = {32'd0, prod_s1, 32'd0};
			SH_64:   term = {prod_s1, 64'd0};
			default: term = '0;
		endcase
		base = load_s1 ? '0 : acc_q;
	end

	always_ff @(posedge clk) begin
		if (issue_s1) begin
			acc_q <= sub_s1 ? (base - term) : (base + term);
		end
	end

	assign acc = acc_q;

endmodule

[design/dpw_ctrl.sv]
// Step sequencer: walks one item through the shared multiplier schedule.
module dpw_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            out_free,
	output dpw_pkg::ctrl_t  ctrl
);
	import dpw_pkg::*;

	step_t      state_q;
	step_t      state_d;
	logic [2:0] cnt_q;
	logic [2:0] cnt_d;
	logic [2:0] last;
	logic       done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= 3'd0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_comb begin
		// multiply steps issue their partial products, then wait for the multiplier to drain
		case (state_q)
			ST_SQ:                         last = 3'd1;
			ST_X4, ST_P2, ST_P4, ST_MIX:   last = 3'd4;
			default:                       last = 3'd0;
		endcase
		done    = (cnt_q == last);
		state_d = state_q;
		cnt_d   = done ? 3'd0 : cnt_q + 3'd1;
		case (state_q)
			ST_IDLE: if (in_valid) state_d = ST_SQ;
			ST_SQ:   if (done) state_d = ST_X4;
			ST_X4:   if (done) state_d = ST_DIFF;
			ST_DIFF: state_d = ST_D1;
			ST_D1:   state_d = ST_D2;
			ST_D2:   state_d = ST_D3;
			ST_D3:   state_d = ST_P2;
			ST_P2:   if (done) state_d = ST_C2;
			ST_C2:   state_d = ST_P4;
			ST_P4:   if (done) state_d = ST_C4;
			ST_C4:   state_d = ST_MIX;
			ST_MIX:  if (done) state_d = ST_ABS;
			ST_ABS:  state_d = ST_OUT;
			ST_OUT:  if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
		ctrl.step  = state_q;
		ctrl.cnt   = cnt_q;
		ctrl.issue = (cnt_q < last);
	end

	a_cnt_only_mul: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q != 3'd0) |-> (state_q == ST_SQ || state_q == ST_X4 || state_q == ST_P2 ||
			state_q == ST_P4 || state_q == ST_MIX))
		else $error("step counter running outside a multiply step");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && in_valid) |=> (state_q == ST_SQ && cnt_q == 3'd0))
		else $error("accepted item did not start the square step");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT && !out_free) |=> (state_q == ST_OUT))
		else $error("left output step while output register was full");

endmodule

[verif/dpw_saw_oscillator_test.sv]
// Self-checking testbench for the DPW2/DPW4 crossfaded sawtooth oscillator.
module dpw_saw_oscillator_test;
	timeunit 1ns;
	timeprecision 1ps;

	import dpw_pkg::*;

	localparam int OUT_W = OUT_BITS_DEF;
	localparam logic [OUT_W-1:0] SAT_HI = {1'b0, {(OUT_W-1){1'b1}}};
	localparam logic [OUT_W-1:0] SAT_LO = {1'b1, {(OUT_W-1){1'b0}}};
	localparam logic [63:0] ALL_ONES = '1;
	localparam int PHASES = 9;
	localparam int PHASE_ITEMS = 110;
	localparam int HOLD_CYCLES = 300;

	typedef struct packed {
		logic             is_cfg;
		cfg_reg_t         reg_sel;
		logic [63:0]      data;
		logic             rs;
		logic             typed;
		logic [OUT_W-1:0] want;
	} step_row_t;

	localparam int PLAN_LEN = 35;
	localparam step_row_t PLAN [PLAN_LEN] = '{
		'{1'b0, CFG_PHASE_INC,  64'd0,          1'b0, 1'b1, '0},
		'{1'b0, CFG_PHASE_INC,  64'd0,          1'b1, 1'b1, '0},
		'{1'b1, CFG_DPW2_GAIN,  ALL_ONES,       1'b0, 1'b0, '0},
		'{1'b1, CFG_DPW4_GAIN,  ALL_ONES,       1'b0, 1'b0, '0},
		'{1'b0, CFG_PHASE_INC,  64'd0,          1'b1, 1'b1, SAT_HI},
		'{1'b0, CFG_PHASE_INC,  64'd0,          1'b0, 1'b1, '0},
		'{1'b1, CFG_MIX_WEIGHT, 64'd65536,      1'b0, 1'b0, '0},
		'{1'b0, CFG_PHASE_INC,  64'd0,          1'b1, 1'b1, SAT_LO},
		'{1'b1, CFG_MIX_WEIGHT, ALL_ONES,       1'b0, 1'b0, '0},
		'{1'b0, CFG_PHASE_INC,  64'd0,          1'b1, 1'b1, SAT_LO},
		'{1'b1, CFG_PHASE_INC,  64'h8000_0000,  1'b0, 1'b0, '0},
		'{1'b1, CFG_DPW2_GAIN,  64'h100_0000,   1'b0, 1'b0, '0},
		'{1'b1, CFG_DPW4_GAIN,  64'h100_0000,   1'b0, 1'b0, '0},
		'{1'b1, CFG_MIX_WEIGHT, 64'd32768,      1'b0, 1'b0, '0},
		'{1'b0, CFG_PHASE_INC,  64'd0,          1'b1, 1'b0, '0},
		'{1'b0, CFG_PHASE_INC,  64'd0,          1'b0, 1'b0, '0},
		'{1'b0, CFG_PHASE_INC,  64'd0,          1'b0, 1'b0, '0},
		'{1'b0, CFG_PHASE_INC,  64'd0,          1'b0, 1'b0, '0},
		'{1'b0, CFG_PHASE_INC,  64'd0,          1'b0, 1'b0, '0},
		'{1'b0, CFG_PHASE_INC,  64'd0,          1'b0, 1'b0, '0},
		'{1'b1, CFG_PHASE_INC,  ALL_ONES,       1'b0, 1'b0, '0},
		'{1'b0, CFG_PHASE_INC,  64'd0,          1'b0, 1'b0, '0},
		'{1'b0, CFG_PHASE_INC,  64'd0,          1'b0, 1'b0, '0},
		'{1'b0, CFG_PHASE_INC,  64'd0,          1'b1, 1'b0, '0},
		'{1'b0, CFG_PHASE_INC,  64'd0,          1'b0, 1'b0, '0},
		'{1'b1, CFG_PHASE_INC,  64'd39370534,   1'b0, 1'b0, '0},
		'{1'b1, CFG_DPW2_GAIN,  64'd457560436,  1'b0, 1'b0, '0},
		'{1'b1, CFG_DPW4_GAIN,  64'd113445000000, 1'b0, 1'b0, '0},
		'{1'b1, CFG_MIX_WEIGHT, 64'd40000,      1'b0, 1'b0, '0},
		'{1'b0, CFG_PHASE_INC,  64'd0,          1'b1, 1'b0, '0},
		'{1'b0, CFG_PHASE_INC,  64'd0,          1'b0, 1'b0, '0},
		'{1'b0, CFG_PHASE_INC,  64'd0,          1'b0, 1'b0, '0},
		'{1'b0, CFG_PHASE_INC,  64'd0,          1'b0, 1'b0, '0},
		'{1'b0, CFG_PHASE_INC,  64'd0,          1'b0, 1'b0, '0},
		'{1'b0, CFG_PHASE_INC,  64'd0,          1'b0, 1'b0, '0}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic restart = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [OUT_W-1:0] sample;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	cfg_reg_t cfg_index = CFG_PHASE_INC;
	logic [63:0] cfg_data = '0;

	// oscillator model: registers and state
	logic [31:0] inc_r = '0;
	logic [63:0] g2_r = '0;
	logic [63:0] g4_r = '0;
	logic [16:0] mix_r = '0;
	logic [31:0] ph = '0;
	logic [63:0] h4 [3] = '{default: '0};
	logic [63:0] h2 = '0;

	logic [OUT_W-1:0] expected_samples [$];
	int errors = 0;
	int n_items = 0;
	int n_restarts = 0;
	int n_writes = 0;
	int n_samples = 0;

	logic typed_pending = 1'b0;
	logic [OUT_W-1:0] typed_val = '0;
	bit calm = 1'b0;
	bit hold_req = 1'b0;

	dpw_saw_oscillator #(.OUT_BITS(OUT_W)) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.restart(restart),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.sample(sample),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// signed Q.60 difference times Q40.24 gain, magnitude capped before mixing
	function automatic longint path_scale(input logic [63:0] d, input logic [63:0] gain);
		logic         neg;
		logic [63:0]  mag;
		logic [127:0] prod;
		logic [127:0] r;
		neg = d[63];
		mag = neg ? -d : d;
		prod = {64'd0, mag} * {64'd0, gain};
		r = prod >> (85 - OUT_W);
		if (r > {87'd0, PATH_CAP})
			r = {87'd0, PATH_CAP};
		return neg ? -longint'(r[63:0]) : longint'(r[63:0]);
	endfunction

	function automatic logic [OUT_W-1:0] saw_next(input logic rs);
		logic [32:0]  m;
		logic [63:0]  x2;
		logic [63:0]  x4;
		logic [63:0]  poly;
		logic [63:0]  dq;
		logic [63:0]  d1;
		logic [63:0]  d2;
		logic [63:0]  d3;
		logic [127:0] sq;
		logic [16:0]  g;
		longint       p2;
		longint       p4;
		longint       v;
		longint       r;
		longint       maxv;
		longint       minv;
		if (rs) begin
			ph = '0;
			h4[0] = '0;
			h4[1] = '0;
			h4[2] = '0;
			h2 = '0;
		end
		m = (ph >= 32'h8000_0000) ? {1'b0, ph} - 33'h0_8000_0000
		                          : 33'h0_8000_0000 - {1'b0, ph};
		x2 = ({31'd0, m} * {31'd0, m}) >> 2;
		sq = {64'd0, x2} * {64'd0, x2};
		x4 = sq[123:60];
		poly = x4 - (x2 << 1);
		dq = x2 - h2;
		h2 = x2;
		d1 = poly - h4[0];
		h4[0] = poly;
		d2 = d1 - h4[1];
		h4[1] = d1;
		d3 = d2 - h4[2];
		h4[2] = d2;
		p2 = path_scale(dq, g2_r);
		p4 = path_scale(d3, g4_r);
		g = (mix_r > G_ONE) ? G_ONE : mix_r;
		v = longint'(g) * p4 + longint'(G_ONE - g) * p2;
		// division truncates toward zero
		r = v / 64'sd65536;
		maxv = (longint'(1) <<< (OUT_W - 1)) - 1;
		minv = -maxv - 1;
		if (r > maxv)
			r = maxv;
		if (r < minv)
			r = minv;
		ph = ph + inc_r;
		return r[OUT_W-1:0];
	endfunction

	// track register writes, accepted items and returned samples
	always @(posedge clk) begin : monitor
		logic [OUT_W-1:0] want;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_PHASE_INC:  inc_r = cfg_data[31:0];
					CFG_DPW2_GAIN:  g2_r = cfg_data;
					CFG_DPW4_GAIN:  g4_r = cfg_data;
					CFG_MIX_WEIGHT: mix_r = cfg_data[16:0];
					default: ;
				endcase
				n_writes++;
			end
			if (in_valid && in_ready) begin
				want = saw_next(restart);
				if (typed_pending)
					want = typed_val;
				expected_samples.push_back(want);
				n_items++;
				if (restart)
					n_restarts++;
			end
			if (out_valid && out_ready) begin
				n_samples++;
				if (expected_samples.size() == 0) begin
					$error("sample: expected none, actual %0d", sample);
					errors++;
				end else begin
					want = expected_samples.pop_front();
					if (sample !== want) begin
						$error("sample: expected %0d, actual %0d", $signed(want), sample);
						errors++;
					end
				end
			end
		end
	end

	// output side: random stall bursts, one long hold on request
	initial begin : sink
		bit held;
		held = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req && !held) begin
				held = 1'b1;
				out_ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				out_ready = 1'b0;
				repeat ($urandom_range(0, 3)) @(negedge clk);
			end else begin
				out_ready = 1'b1;
			end
		end
	end

	task automatic settle();
		in_valid = 1'b0;
		while (expected_samples.size() != 0)
			@(negedge clk);
	endtask

	task automatic push_sample(input logic rs);
		in_valid = 1'b1;
		restart = rs;
		do
			@(posedge clk);
		while (!in_ready);
		@(negedge clk);
		if (!calm && $urandom_range(0, 3) == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [63:0] val);
		settle();
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// kind 0-2: musical pitch, 3: raw random words, 4: corner values
	task automatic retune(input int kind);
		int unsigned per;
		logic [63:0] cube;
		logic [63:0] inc_v;
		logic [63:0] g2_v;
		logic [63:0] g4_v;
		logic [63:0] mix_v;
		case (kind)
			3: begin
				inc_v = {$urandom, $urandom};
				g2_v = {$urandom, $urandom};
				g4_v = {$urandom, $urandom};
				mix_v = {$urandom, $urandom};
			end
			4: begin
				case ($urandom_range(0, 2))
					0: inc_v = 64'd0;
					1: inc_v = 64'h8000_0000;
					default: inc_v = ALL_ONES;
				endcase
				g2_v = ($urandom_range(0, 1) != 0) ? ALL_ONES : {$urandom, $urandom};
				g4_v = ($urandom_range(0, 1) != 0) ? ALL_ONES : 64'd0;
				case ($urandom_range(0, 2))
					0: mix_v = 64'd0;
					1: mix_v = 64'd65536;
					default: mix_v = 64'h1_FFFF;
				endcase
			end
			default: begin
				per = ($urandom_range(0, 3) == 0) ? $urandom_range(200, 4000)
				                                  : $urandom_range(2, 200);
				inc_v = 64'h1_0000_0000 / per;
				g2_v = 64'(per) << 22;
				cube = 64'(per) * 64'(per) * 64'(per);
				g4_v = (cube << 24) / 192;
				mix_v = 64'($urandom_range(0, 65536));
			end
		endcase
		write_reg(CFG_PHASE_INC, inc_v);
		write_reg(CFG_DPW2_GAIN, g2_v);
		write_reg(CFG_DPW4_GAIN, g4_v);
		write_reg(CFG_MIX_WEIGHT, mix_v);
	endtask

	initial begin : stimulus
		int spin;
		int kind;
		arst_n = 1'b0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		foreach (PLAN[k]) begin
			if (PLAN[k].is_cfg) begin
				write_reg(PLAN[k].reg_sel, PLAN[k].data);
			end else begin
				typed_pending = PLAN[k].typed;
				typed_val = PLAN[k].want;
				push_sample(PLAN[k].rs);
				typed_pending = 1'b0;
			end
		end

		for (int p = 0; p < PHASES; p++) begin
			calm = (p == 2) || (p == PHASES - 1);
			kind = (p == 0) ? 3 : (p == 1) ? 4 : int'($urandom_range(0, 4));
			retune(kind);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (p == 3 && i == 40)
					hold_req = 1'b1;
				// stop feeding until every sample is back, then resume
				if (p == 5 && i == 50)
					settle();
				push_sample((i == 0) ? $urandom_range(0, 1) == 1
				                     : $urandom_range(0, 15) == 0);
			end
		end
		in_valid = 1'b0;

		spin = 0;
		while (expected_samples.size() != 0 && spin < 5000) begin
			@(negedge clk);
			spin++;
		end
		repeat (40) @(negedge clk);
		if (expected_samples.size() != 0)
			$error("sample: %0d expected samples never arrived", expected_samples.size());

		$display("Ran %0d items (%0d restarts) through %0d register writes,",
			n_items, n_restarts, n_writes);
		$display("  %0d samples compared, %0d mismatches.", n_samples, errors);
		if (errors == 0 && expected_samples.size() == 0)
			$display("dpw_saw_oscillator test passed");
		else
			$display("dpw_saw_oscillator test failed");
		$finish;
	end

	initial begin : watchdog
		#2_000_000;
		$display("dpw_saw_oscillator test failed");
		$finish;
	end

endmodule
